### rtl/c22s_pkg.sv
// Shared types, widths, status codes and helper functions for the 2x2 complex solver.
`timescale 1ns / 1ps
package c22s_pkg;

  localparam int IN_W      = 16;
  localparam int PROD_W    = 2 * IN_W;
  localparam int CW        = PROD_W + 2;
  localparam int SQ_W      = 2 * CW;
  localparam int NUM_W     = SQ_W + 1;
  localparam int DEN_W     = SQ_W;
  localparam int OUT_W     = 32;
  localparam int OUT_FRAC  = 16;
  localparam int QBITS     = OUT_W;
  localparam int DIV_LAT   = QBITS + 2;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [1:0] ST_UNIQUE   = 2'd0;
  localparam logic [1:0] ST_INFINITE = 2'd1;
  localparam logic [1:0] ST_NONE     = 2'd2;

  typedef struct packed {
    logic signed [PROD_W-1:0] rr;
    logic signed [PROD_W-1:0] ii;
    logic signed [PROD_W-1:0] ri;
    logic signed [PROD_W-1:0] ir;
  } cprod_t;

  // word handed from front to back through the queue
  typedef struct packed {
    logic signed [CW-1:0] det_re;
    logic signed [CW-1:0] det_im;
    logic signed [CW-1:0] nx_re;
    logic signed [CW-1:0] nx_im;
    logic signed [CW-1:0] ny_re;
    logic signed [CW-1:0] ny_im;
    logic [1:0]           status;
  } fe_word_t;

  function automatic cprod_t cmul_terms(input logic signed [IN_W-1:0] pr,
                                        input logic signed [IN_W-1:0] pi,
                                        input logic signed [IN_W-1:0] qr,
                                        input logic signed [IN_W-1:0] qi);
    cprod_t p;
    p.rr = PROD_W'(pr * qr);
    p.ii = PROD_W'(pi * qi);
    p.ri = PROD_W'(pr * qi);
    p.ir = PROD_W'(pi * qr);
    return p;
  endfunction

  function automatic logic signed [CW-1:0] ext_cw(input logic signed [PROD_W-1:0] v);
    return {{(CW-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic logic signed [CW-1:0] cre(input cprod_t p);
    return ext_cw(p.rr) - ext_cw(p.ii);
  endfunction

  function automatic logic signed [CW-1:0] cim(input cprod_t p);
    return ext_cw(p.ri) + ext_cw(p.ir);
  endfunction

  function automatic logic signed [NUM_W-1:0] ext_num(input logic signed [SQ_W-1:0] v);
    return {v[SQ_W-1], v};
  endfunction

endpackage

### rtl/c22s_front.sv
// Front end: takes a system word, forms the complex products, det and the numerators.
`timescale 1ns / 1ps
module c22s_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [c22s_pkg::IN_W-1:0] a_re,
  input  logic signed [c22s_pkg::IN_W-1:0] a_im,
  input  logic signed [c22s_pkg::IN_W-1:0] b_re,
  input  logic signed [c22s_pkg::IN_W-1:0] b_im,
  input  logic signed [c22s_pkg::IN_W-1:0] c_re,
  input  logic signed [c22s_pkg::IN_W-1:0] c_im,
  input  logic signed [c22s_pkg::IN_W-1:0] d_re,
  input  logic signed [c22s_pkg::IN_W-1:0] d_im,
  input  logic signed [c22s_pkg::IN_W-1:0] e_re,
  input  logic signed [c22s_pkg::IN_W-1:0] e_im,
  input  logic signed [c22s_pkg::IN_W-1:0] f_re,
  input  logic signed [c22s_pkg::IN_W-1:0] f_im,
  output logic                            fe_valid,
  input  logic                            fe_ready,
  output c22s_pkg::fe_word_t              fe_word
);
  import c22s_pkg::*;

  logic   v1;
  logic   r1;
  logic   r2;
  cprod_t ad, cb, ed, bf, af, ce;
  logic signed [CW-1:0] det_re, det_im;
  logic   eq_bf_de;

  assign r2       = !fe_valid || fe_ready;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      fe_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) fe_valid <= v1;
    end
  end

  // products of all six complex terms
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      ad <= cmul_terms(a_re, a_im, d_re, d_im);
      cb <= cmul_terms(c_re, c_im, b_re, b_im);
      ed <= cmul_terms(e_re, e_im, d_re, d_im);
      bf <= cmul_terms(b_re, b_im, f_re, f_im);
      af <= cmul_terms(a_re, a_im, f_re, f_im);
      ce <= cmul_terms(c_re, c_im, e_re, e_im);
    end
  end

  assign det_re   = cre(ad) - cre(cb);
  assign det_im   = cim(ad) - cim(cb);
  assign eq_bf_de = (cre(bf) == cre(ed)) && (cim(bf) == cim(ed));

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      fe_word.det_re <= det_re;
      fe_word.det_im <= det_im;
      fe_word.nx_re  <= cre(ed) - cre(bf);
      fe_word.nx_im  <= cim(ed) - cim(bf);
      fe_word.ny_re  <= cre(af) - cre(ce);
      fe_word.ny_im  <= cim(af) - cim(ce);
      if (det_re == '0 && det_im == '0) begin
        fe_word.status <= eq_bf_de ? ST_INFINITE : ST_NONE;
      end else begin
        fe_word.status <= ST_UNIQUE;
      end
    end
  end

endmodule

### rtl/c22s_fifo.sv
// Short queue between the front end and the divider back end.
`timescale 1ns / 1ps
module c22s_fifo #(
  parameter int DEPTH = c22s_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  c22s_pkg::fe_word_t push_word,
  output logic               pop_valid,
  input  logic               pop_ready,
  output c22s_pkg::fe_word_t pop_word
);
  import c22s_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  fe_word_t          mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CNTW-1:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_word   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH)) else $error("queue fill above depth");
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("push lost");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("pop lost");

endmodule

### rtl/c22s_div.sv
// Pipelined restoring divider: signed numerator over positive denominator, Q.16, saturating.
`timescale 1ns / 1ps
module c22s_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [c22s_pkg::NUM_W-1:0]  num,
  input  logic        [c22s_pkg::DEN_W-1:0]  den,
  output logic        [c22s_pkg::OUT_W-1:0]  value,
  output logic                               sat
);
  import c22s_pkg::*;

  logic [DEN_W-1:0] rem   [QBITS+1];
  logic [DEN_W-1:0] dv    [QBITS+1];
  logic [QBITS-1:0] low   [QBITS+1];
  logic [QBITS-1:0] quo   [QBITS+1];
  logic             neg   [QBITS+1];
  logic             ovf   [QBITS+1];
  logic [NUM_W-1:0] mag_w;
  logic [DEN_W-1:0] mag;
  logic [QBITS-1:0] limit;

  assign mag_w = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign mag   = mag_w[DEN_W-1:0];

  // sign, magnitude and overflow check: quotient of 2^32 or more cannot fit
  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= num[NUM_W-1];
      ovf[0] <= {{OUT_FRAC{1'b0}}, mag} >= {den, {OUT_FRAC{1'b0}}};
      rem[0] <= {{OUT_FRAC{1'b0}}, mag[DEN_W-1:OUT_FRAC]};
      low[0] <= {mag[OUT_FRAC-1:0], {(QBITS-OUT_FRAC){1'b0}}};
      quo[0] <= '0;
      dv[0]  <= den;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_iter
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {rem[k], low[k][QBITS-1]};
    assign ge = t >= {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? DEN_W'(t - {1'b0, dv[k]}) : t[DEN_W-1:0];
        low[k+1] <= {low[k][QBITS-2:0], 1'b0};
        quo[k+1] <= {quo[k][QBITS-2:0], ge};
        dv[k+1]  <= dv[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  assign limit = neg[QBITS] ? {1'b1, {(QBITS-1){1'b0}}} : {1'b0, {(QBITS-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf[QBITS] || quo[QBITS] > limit) begin
        sat   <= 1'b1;
        value <= limit;
      end else begin
        sat   <= 1'b0;
        value <= neg[QBITS] ? OUT_W'(-quo[QBITS]) : quo[QBITS];
      end
    end
  end

endmodule

### rtl/c22s_back.sv
// Back end: Cramer numerators over |det|^2, four dividers and the output register.
`timescale 1ns / 1ps
module c22s_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fe_valid,
  output logic                            fe_ready,
  input  c22s_pkg::fe_word_t              fe_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic signed [c22s_pkg::OUT_W-1:0] x_re,
  output logic signed [c22s_pkg::OUT_W-1:0] x_im,
  output logic signed [c22s_pkg::OUT_W-1:0] y_re,
  output logic signed [c22s_pkg::OUT_W-1:0] y_im,
  output logic                            saturated
);
  import c22s_pkg::*;

  localparam int NST = DIV_LAT + 3;

  logic             en;
  logic             vld [NST-1];
  logic [1:0]       st  [NST-1];
  logic signed [SQ_W-1:0] m_dd_r, m_dd_i;
  logic signed [SQ_W-1:0] m_xr_r, m_xi_i, m_xi_r, m_xr_i;
  logic signed [SQ_W-1:0] m_yr_r, m_yi_i, m_yi_r, m_yr_i;
  logic        [DEN_W-1:0] den;
  logic signed [NUM_W-1:0] nxr, nxi, nyr, nyi;
  logic [OUT_W-1:0] qxr, qxi, qyr, qyi;
  logic             sxr, sxi, syr, syi;

  // one enable for the whole pipe: hold everything while the result waits
  assign en       = !out_valid || out_ready;
  assign fe_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST - 1; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= fe_valid;
      for (int k = 1; k < NST - 1; k++) vld[k] <= vld[k-1];
      out_valid <= vld[NST-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= fe_word.status;
      for (int k = 1; k < NST - 1; k++) st[k] <= st[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_dd_r <= fe_word.det_re * fe_word.det_re;
      m_dd_i <= fe_word.det_im * fe_word.det_im;
      m_xr_r <= fe_word.nx_re * fe_word.det_re;
      m_xi_i <= fe_word.nx_im * fe_word.det_im;
      m_xi_r <= fe_word.nx_im * fe_word.det_re;
      m_xr_i <= fe_word.nx_re * fe_word.det_im;
      m_yr_r <= fe_word.ny_re * fe_word.det_re;
      m_yi_i <= fe_word.ny_im * fe_word.det_im;
      m_yi_r <= fe_word.ny_im * fe_word.det_re;
      m_yr_i <= fe_word.ny_re * fe_word.det_im;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den <= DEN_W'(m_dd_r + m_dd_i);
      nxr <= ext_num(m_xr_r) + ext_num(m_xi_i);
      nxi <= ext_num(m_xi_r) - ext_num(m_xr_i);
      nyr <= ext_num(m_yr_r) + ext_num(m_yi_i);
      nyi <= ext_num(m_yi_r) - ext_num(m_yr_i);
    end
  end

  c22s_div u_div_xr (.clk(clk), .en(en), .num(nxr), .den(den), .value(qxr), .sat(sxr));
  c22s_div u_div_xi (.clk(clk), .en(en), .num(nxi), .den(den), .value(qxi), .sat(sxi));
  c22s_div u_div_yr (.clk(clk), .en(en), .num(nyr), .den(den), .value(qyr), .sat(syr));
  c22s_div u_div_yi (.clk(clk), .en(en), .num(nyi), .den(den), .value(qyi), .sat(syi));

  // drop the quotients of a singular system
  always_ff @(posedge clk) begin
    if (en) begin
      status <= st[NST-2];
      if (st[NST-2] == ST_UNIQUE) begin
        x_re      <= qxr;
        x_im      <= qxi;
        y_re      <= qyr;
        y_im      <= qyi;
        saturated <= sxr || sxi || syr || syi;
      end else begin
        x_re      <= '0;
        x_im      <= '0;
        y_re      <= '0;
        y_im      <= '0;
        saturated <= 1'b0;
      end
    end
  end

endmodule

### rtl/complex_2x2_system_solver.sv
// Top level of the 2x2 complex linear system solver (Cramer's rule).
// Usage:
//   Input channel in_valid/in_ready carries one system word: the twelve signed
//   Q7.8 parts of a, b, c, d, e, f for a*x+b*y=e, c*x+d*y=f.
//   Output channel out_valid/out_ready carries status, x and y in signed
//   Q15.16 (truncated toward zero) and the saturated flag.
//   Throughput: one system per cycle, sustained, while the receiver keeps up.
//   The delay from acceptance to out_valid is set by the 32-stage restoring
//   divider pipeline plus the product, sum and queue stages.
//   The front end (products, det, singular check) feeds a four-word queue;
//   the back end (|det|^2 numerators, four dividers, output register) advances
//   as one pipe that holds whenever a result waits on out_ready.
//   While the back end holds, the front end keeps taking words until the queue
//   fills, after which in_ready drops.
//   Singular systems give status 1 or 2 with zero unknowns and no saturation.
//   Reset (synchronous, active high) empties the queue and all pipe stages;
//   no result is lost or repeated across a stall.
`timescale 1ns / 1ps
module complex_2x2_system_solver #(
  parameter int FIFO_DEPTH = c22s_pkg::FIFO_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [c22s_pkg::IN_W-1:0]   a_re,
  input  logic signed [c22s_pkg::IN_W-1:0]   a_im,
  input  logic signed [c22s_pkg::IN_W-1:0]   b_re,
  input  logic signed [c22s_pkg::IN_W-1:0]   b_im,
  input  logic signed [c22s_pkg::IN_W-1:0]   c_re,
  input  logic signed [c22s_pkg::IN_W-1:0]   c_im,
  input  logic signed [c22s_pkg::IN_W-1:0]   d_re,
  input  logic signed [c22s_pkg::IN_W-1:0]   d_im,
  input  logic signed [c22s_pkg::IN_W-1:0]   e_re,
  input  logic signed [c22s_pkg::IN_W-1:0]   e_im,
  input  logic signed [c22s_pkg::IN_W-1:0]   f_re,
  input  logic signed [c22s_pkg::IN_W-1:0]   f_im,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic signed [c22s_pkg::OUT_W-1:0]  x_re,
  output logic signed [c22s_pkg::OUT_W-1:0]  x_im,
  output logic signed [c22s_pkg::OUT_W-1:0]  y_re,
  output logic signed [c22s_pkg::OUT_W-1:0]  y_im,
  output logic                               saturated
);
  import c22s_pkg::*;

  logic     fe_valid, fe_ready;
  fe_word_t fe_word;
  logic     q_valid, q_ready;
  fe_word_t q_word;

  c22s_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .c_re(c_re), .c_im(c_im), .d_re(d_re), .d_im(d_im),
    .e_re(e_re), .e_im(e_im), .f_re(f_re), .f_im(f_im),
    .fe_valid(fe_valid), .fe_ready(fe_ready), .fe_word(fe_word)
  );

  c22s_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push_valid(fe_valid), .push_ready(fe_ready), .push_word(fe_word),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_word(q_word)
  );

  c22s_back u_back (
    .clk(clk), .rst(rst),
    .fe_valid(q_valid), .fe_ready(q_ready), .fe_word(q_word),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im), .saturated(saturated)
  );

endmodule

### tb/sv/complex_2x2_system_solver_tb.sv
// Self-checking testbench for the 2x2 complex system solver: random and directed systems.
`timescale 1ns / 1ps
module complex_2x2_system_solver_tb;
  import c22s_pkg::*;

  typedef struct packed {
    logic signed [15:0] a_re, a_im, b_re, b_im, c_re, c_im;
    logic signed [15:0] d_re, d_im, e_re, e_im, f_re, f_im;
  } system_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] x_re, x_im, y_re, y_im;
    logic               saturated;
  } solution_t;

  typedef struct {
    longint re;
    longint im;
  } cnum_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  system_t sys_word = '0;
  solution_t got;

  system_t   systems_to_send[$];
  solution_t solutions_due[$];
  int accepted_count = 0;
  int error_count = 0;

  always #1 clk = ~clk;

  complex_2x2_system_solver DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .a_re(sys_word.a_re), .a_im(sys_word.a_im), .b_re(sys_word.b_re), .b_im(sys_word.b_im),
    .c_re(sys_word.c_re), .c_im(sys_word.c_im), .d_re(sys_word.d_re), .d_im(sys_word.d_im),
    .e_re(sys_word.e_re), .e_im(sys_word.e_im), .f_re(sys_word.f_re), .f_im(sys_word.f_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(got.status), .x_re(got.x_re), .x_im(got.x_im),
    .y_re(got.y_re), .y_im(got.y_im), .saturated(got.saturated)
  );

  function automatic cnum_t cx(input logic signed [15:0] re, input logic signed [15:0] im);
    cnum_t r;
    r.re = re;
    r.im = im;
    return r;
  endfunction

  function automatic cnum_t cx_mul(input cnum_t p, input cnum_t q);
    cnum_t r;
    r.re = p.re * q.re - p.im * q.im;
    r.im = p.re * q.im + p.im * q.re;
    return r;
  endfunction

  function automatic cnum_t cx_sub(input cnum_t p, input cnum_t q);
    cnum_t r;
    r.re = p.re - q.re;
    r.im = p.im - q.im;
    return r;
  endfunction

  // Truncate num/den toward zero in Q15.16 and clamp to 32 bits.
  function automatic logic signed [31:0] q16_quotient(input logic signed [127:0] num,
                                                      input logic signed [127:0] den,
                                                      inout logic sat);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] lim;
    logic         neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q   = (mag << 16) / den;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic void cx_divide(input cnum_t n, input cnum_t d, output logic signed [31:0] re,
                                    output logic signed [31:0] im, inout logic sat);
    logic signed [127:0] den, nr, ni;
    den = 128'(d.re) * 128'(d.re) + 128'(d.im) * 128'(d.im);
    nr  = 128'(n.re) * 128'(d.re) + 128'(n.im) * 128'(d.im);
    ni  = 128'(n.im) * 128'(d.re) - 128'(n.re) * 128'(d.im);
    re = q16_quotient(nr, den, sat);
    im = q16_quotient(ni, den, sat);
  endfunction

  function automatic solution_t solve_system(input system_t s);
    cnum_t a, b, c, d, e, f, det, bf, de;
    solution_t r;
    logic sat;
    a = cx(s.a_re, s.a_im); b = cx(s.b_re, s.b_im); c = cx(s.c_re, s.c_im);
    d = cx(s.d_re, s.d_im); e = cx(s.e_re, s.e_im); f = cx(s.f_re, s.f_im);
    r = '0;
    sat = 1'b0;
    det = cx_sub(cx_mul(a, d), cx_mul(c, b));
    if (det.re == 0 && det.im == 0) begin
      bf = cx_mul(b, f);
      de = cx_mul(d, e);
      r.status = (bf.re == de.re && bf.im == de.im) ? ST_INFINITE : ST_NONE;
      return r;
    end
    cx_divide(cx_sub(cx_mul(e, d), cx_mul(b, f)), det, r.x_re, r.x_im, sat);
    cx_divide(cx_sub(cx_mul(a, f), cx_mul(c, e)), det, r.y_re, r.y_im, sat);
    r.status = ST_UNIQUE;
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic signed [15:0] small_val(input int span);
    return 16'($signed($urandom_range(2 * span, 0)) - span);
  endfunction

  // Dependent rows: c = k*a, d = k*b, and f = k*e unless broken on purpose.
  function automatic system_t singular_system(input bit consistent);
    system_t s;
    cnum_t k, a, b, e, t;
    s = '0;
    s.a_re = small_val(255); s.a_im = small_val(255);
    s.b_re = small_val(255); s.b_im = small_val(255);
    s.e_re = small_val(255); s.e_im = small_val(255);
    k.re = $signed($urandom_range(128, 0)) - 64;
    k.im = $signed($urandom_range(128, 0)) - 64;
    a = cx(s.a_re, s.a_im); b = cx(s.b_re, s.b_im); e = cx(s.e_re, s.e_im);
    t = cx_mul(k, a); s.c_re = 16'(t.re); s.c_im = 16'(t.im);
    t = cx_mul(k, b); s.d_re = 16'(t.re); s.d_im = 16'(t.im);
    t = cx_mul(k, e); s.f_re = 16'(t.re); s.f_im = 16'(t.im);
    if (!consistent) s.f_re = s.f_re + 16'sd1;
    return s;
  endfunction

  function automatic system_t random_system();
    system_t s;
    int pick;
    pick = $urandom_range(9, 0);
    if (pick < 4) s = system_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    else if (pick < 7) begin
      s.a_re = small_val(1024); s.a_im = small_val(1024); s.b_re = small_val(1024);
      s.b_im = small_val(1024); s.c_re = small_val(1024); s.c_im = small_val(1024);
      s.d_re = small_val(1024); s.d_im = small_val(1024); s.e_re = small_val(1024);
      s.e_im = small_val(1024); s.f_re = small_val(1024); s.f_im = small_val(1024);
    end else s = singular_system(pick == 7);
    return s;
  endfunction

  function automatic bit idle_now();
    if (accepted_count >= 200 && accepted_count < 330) return 1'b0;
    return $urandom_range(99, 0) < 35;
  endfunction

  // Driver: hold the word until it is taken, then advance to the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        solutions_due.push_back(solve_system(sys_word));
        accepted_count = accepted_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (systems_to_send.size() > 0 && !idle_now()) begin
          sys_word <= systems_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
      error_count = error_count + 1;
    end
  endtask

  // Monitor: compare each word taken against the oldest prediction.
  always @(posedge clk) begin
    solution_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (solutions_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d", $time, got.status);
          error_count = error_count + 1;
        end else begin
          want = solutions_due.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("x_re", want.x_re, got.x_re);
          report_field("x_im", want.x_im, got.x_im);
          report_field("y_re", want.y_re, got.y_re);
          report_field("y_im", want.y_im, got.y_im);
          report_field("saturated", 32'(want.saturated), 32'(got.saturated));
        end
      end
      out_ready <= !idle_now();
    end
  end

  initial begin
    system_t s;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // zero system, extremes, identity, saturation both ways, singular cases
    systems_to_send.push_back('0);
    systems_to_send.push_back({12{16'sh7FFF}});
    systems_to_send.push_back({12{16'sh8000}});
    s = '0; s.a_re = 16'sh0100; s.d_re = 16'sh0100; s.e_re = 16'sh7FFF; s.f_im = 16'sh8000;
    systems_to_send.push_back(s);
    s = '0; s.a_re = 16'sd1; s.d_re = 16'sh7FFF; s.c_re = 16'sh7FFE; s.b_re = 16'sd1;
    s.e_re = 16'sh7FFF; s.f_re = 16'sd1;
    systems_to_send.push_back(s);
    s.e_re = 16'sh8000; s.f_im = 16'sh7FFF;
    systems_to_send.push_back(s);
    s = '0; s.a_im = 16'sd1; s.d_im = 16'sd1; s.e_re = 16'sh8000; s.f_re = 16'sh7FFF;
    systems_to_send.push_back(s);
    s = {16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
         16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
    systems_to_send.push_back(s);
    s = '0; s.e_re = 16'sd5;
    systems_to_send.push_back(s);
    repeat (4) systems_to_send.push_back(singular_system(1'b1));
    repeat (4) systems_to_send.push_back(singular_system(1'b0));
    repeat (150) systems_to_send.push_back(random_system());
    // let everything drain before carrying on
    wait (systems_to_send.size() == 0 && !in_valid && solutions_due.size() == 0);
    repeat (400) systems_to_send.push_back(random_system());
    wait (systems_to_send.size() == 0 && !in_valid && solutions_due.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("** complex_2x2_system_solver: PASSED **");
    else $display("** complex_2x2_system_solver: FAILED **");
    $finish;
  end

  initial begin
    #400000;
    $display("** complex_2x2_system_solver: FAILED **");
    $finish;
  end

endmodule
